[src/tsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_pkg
// Shared types and constants of the scratchpad temperature decoder.
// ----------------------------------------------------------------------------
package tsd_pkg;

	localparam int PAD_BYTES   = 9;
	localparam int IDX_W       = 4;
	localparam int VAL_W       = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAD_BYTES - 1);

	localparam logic [7:0] CRC_POLY    = 8'h8C;
	localparam logic [7:0] FAMILY_HALF = 8'h10;

	localparam logic [1:0] RES_9BIT  = 2'b00;
	localparam logic [1:0] RES_10BIT = 2'b01;
	localparam logic [1:0] RES_11BIT = 2'b10;

	localparam logic [1:0] REG_FAMILY = 2'd0;
	localparam logic [1:0] REG_MIN    = 2'd1;
	localparam logic [1:0] REG_MAX    = 2'd2;

	localparam logic [IDX_W-1:0] POS_LSB    = 4'd0;
	localparam logic [IDX_W-1:0] POS_MSB    = 4'd1;
	localparam logic [IDX_W-1:0] POS_CFG    = 4'd4;
	localparam logic [IDX_W-1:0] POS_REMAIN = 4'd6;
	localparam logic [IDX_W-1:0] POS_PER_C  = 4'd7;

	typedef struct packed {
		logic [7:0] lsb;
		logic [7:0] msb;
		logic [7:0] cfg;
		logic [7:0] remain;
		logic [7:0] per_c;
		logic       crc_ok;
	} job_t;

	typedef struct packed {
		logic [7:0]         family;
		logic signed [15:0] min_limit;
		logic signed [15:0] max_limit;
	} cfg_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[src/temp_sensor_scratchpad_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_sensor_scratchpad_decoder_top
// Decodes 1-Wire sensor scratchpads into a checked temperature item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one scratchpad byte per item, with
//   first marking byte 0. Bytes are taken one per cycle; in_stall rises only
//   on the ninth byte while both job queue entries are occupied.
//   Output channel (out_valid / out_stall): one item per nine-byte
//   scratchpad carrying temperature_sixteenths, accepted and crc_ok.
//   For family 0x10 with a valid count, a 5-step shift-subtract divider
//   produces the count fraction. The back end decodes one scratchpad at a
//   time, and bytes stream at one per cycle while in_stall is low.
//   A stalled output item holds; the back end waits and the queue fills,
//   after which the front end stalls on the next last byte.
//   Configuration (cfg_valid / cfg_ready, always ready): index 0 family code,
//   1 minimum limit, 2 maximum limit; write only while idle.
//   Reset (arst_n low) clears the byte count, CRC, queue and output valid and
//   restores family 0x28, window -160 to 800.
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               first,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_sixteenths,
	output logic               accepted,
	output logic               crc_ok,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	tsd_pkg::cfg_t cfg_q;
	tsd_pkg::job_t push_job, pop_job;
	logic          push, pop, queue_full, queue_empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.family    <= 8'd40;
			cfg_q.min_limit <= -16'sd160;
			cfg_q.max_limit <= 16'sd800;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tsd_pkg::REG_FAMILY: cfg_q.family    <= cfg_data[7:0];
				tsd_pkg::REG_MIN:    cfg_q.min_limit <= $signed(cfg_data);
				tsd_pkg::REG_MAX:    cfg_q.max_limit <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	tsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.first      (first),
		.push       (push),
		.push_job   (push_job),
		.queue_full (queue_full)
	);

	tsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.full     (queue_full),
		.empty    (queue_empty)
	);

	tsd_back u_back (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cfg                    (cfg_q),
		.queue_empty            (queue_empty),
		.pop_job                (pop_job),
		.pop                    (pop),
		.out_valid              (out_valid),
		.out_stall              (out_stall),
		.temperature_sixteenths (temperature_sixteenths),
		.accepted               (accepted),
		.crc_ok                 (crc_ok)
	);

endmodule

[src/tsd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_front
// Takes scratchpad bytes, runs the CRC-8, keeps the bytes needed for the
// decode and hands one job per complete scratchpad to the queue.
// ----------------------------------------------------------------------------
module tsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              first,
	output logic              push,
	output tsd_pkg::job_t     push_job,
	input  logic              queue_full
);

	logic [tsd_pkg::IDX_W-1:0] idx_q;
	logic [7:0]                crc_q;
	logic [7:0]                lsb_q, msb_q, cfg_q, remain_q, per_c_q;

	logic [tsd_pkg::IDX_W-1:0] idx_eff;
	logic [7:0]                crc_eff;
	logic                      is_last;
	logic                      take;

	assign idx_eff  = first ? '0 : idx_q;
	assign crc_eff  = first ? 8'h00 : crc_q;
	assign is_last  = (idx_eff == tsd_pkg::LAST_IDX);
	assign in_stall = is_last && queue_full;
	assign take     = in_valid && !in_stall;
	assign push     = take && is_last;

	assign push_job.lsb    = lsb_q;
	assign push_job.msb    = msb_q;
	assign push_job.cfg    = cfg_q;
	assign push_job.remain = remain_q;
	assign push_job.per_c  = per_c_q;
	assign push_job.crc_ok = (data_byte == crc_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= 8'h00;
		end else if (take) begin
			if (is_last) begin
				idx_q <= '0;
				crc_q <= 8'h00;
			end else begin
				idx_q <= idx_eff + 1'b1;
				crc_q <= tsd_pkg::crc8_step(crc_eff, data_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && !is_last) begin
			case (idx_eff)
				tsd_pkg::POS_LSB:    lsb_q    <= data_byte;
				tsd_pkg::POS_MSB:    msb_q    <= data_byte;
				tsd_pkg::POS_CFG:    cfg_q    <= data_byte;
				tsd_pkg::POS_REMAIN: remain_q <= data_byte;
				tsd_pkg::POS_PER_C:  per_c_q  <= data_byte;
				default: ;
			endcase
		end
	end

endmodule

[src/tsd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_queue
// Two-entry job queue between the byte front end and the decode back end.
// ----------------------------------------------------------------------------
module tsd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tsd_pkg::job_t push_job,
	input  logic          pop,
	output tsd_pkg::job_t pop_job,
	output logic          full,
	output logic          empty
);

	tsd_pkg::job_t mem_q [tsd_pkg::QUEUE_DEPTH];
	logic          wr_ptr_q, rd_ptr_q;
	logic [1:0]    count_q;

	assign full    = (count_q == 2'(tsd_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == 2'd0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[src/tsd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsd_back
// Decodes one job: count refinement divide, resolution mask, window check,
// and drives the output register.
// ----------------------------------------------------------------------------
module tsd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tsd_pkg::cfg_t      cfg,
	input  logic               queue_empty,
	input  tsd_pkg::job_t      pop_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] temperature_sixteenths,
	output logic               accepted,
	output logic               crc_ok
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_CALC = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                          state_q;
	tsd_pkg::job_t                   job_q;
	logic                            use_count_q;
	logic [8:0]                      rem_q;
	logic [4:0]                      quo_q;
	logic [2:0]                      cnt_q;
	logic signed [tsd_pkg::VAL_W-1:0] val_q;
	logic                            out_valid_q;

	logic                            is_half;
	logic                            count_ok;
	logic [8:0]                      div_t;
	logic                            div_ge;
	logic signed [15:0]              raw;
	logic [15:0]                     masked;
	logic signed [tsd_pkg::VAL_W-1:0] calc_val;
	logic signed [tsd_pkg::VAL_W-1:0] lo, hi;
	logic                            in_window;
	logic                            out_free;

	assign is_half  = (cfg.family == tsd_pkg::FAMILY_HALF);
	assign count_ok = (pop_job.per_c != 8'h00) && (pop_job.remain <= pop_job.per_c);
	assign pop      = (state_q == ST_IDLE) && !queue_empty;

	assign div_t  = (cnt_q == 3'd0) ? rem_q : {rem_q[7:0], 1'b0};
	assign div_ge = (div_t >= {1'b0, job_q.per_c});

	assign raw = $signed({job_q.msb, job_q.lsb});

	always_comb begin
		case (job_q.cfg[6:5])
			tsd_pkg::RES_9BIT:  masked = {job_q.msb, job_q.lsb[7:3], 3'b000};
			tsd_pkg::RES_10BIT: masked = {job_q.msb, job_q.lsb[7:2], 2'b00};
			tsd_pkg::RES_11BIT: masked = {job_q.msb, job_q.lsb[7:1], 1'b0};
			default:            masked = {job_q.msb, job_q.lsb};
		endcase
	end

	always_comb begin
		if (is_half) begin
			calc_val = tsd_pkg::VAL_W'(raw) <<< 3;
			if (use_count_q) begin
				calc_val = calc_val - tsd_pkg::VAL_W'(4)
					+ $signed({{(tsd_pkg::VAL_W-5){1'b0}}, quo_q});
			end
		end else begin
			calc_val = tsd_pkg::VAL_W'($signed(masked));
		end
	end

	assign lo        = tsd_pkg::VAL_W'(cfg.min_limit);
	assign hi        = tsd_pkg::VAL_W'(cfg.max_limit);
	assign in_window = job_q.crc_ok && (val_q >= lo) && (val_q <= hi);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 3'd0;
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!queue_empty) begin
						cnt_q   <= 3'd0;
						state_q <= (is_half && count_ok) ? ST_DIV : ST_CALC;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!queue_empty) begin
					job_q       <= pop_job;
					use_count_q <= is_half && count_ok;
					rem_q       <= {1'b0, pop_job.per_c} - {1'b0, pop_job.remain};
					quo_q       <= 5'd0;
				end
			end
			ST_DIV: begin
				rem_q <= div_ge ? (div_t - {1'b0, job_q.per_c}) : div_t;
				quo_q <= {quo_q[3:0], div_ge};
			end
			ST_CALC: begin
				val_q <= calc_val;
			end
			ST_EMIT: begin
				if (out_free) begin
					temperature_sixteenths <= in_window ? val_q[15:0] : 16'sd0;
					accepted               <= in_window;
					crc_ok                 <= job_q.crc_ok;
				end
			end
			default: ;
		endcase
	end

endmodule
